>>> src/fixed_capacity_set_table_macros.svh
// Assertion macros for the set table top level.
`ifndef FIXED_CAPACITY_SET_TABLE_MACROS_SVH
`define FIXED_CAPACITY_SET_TABLE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FCST_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the next clock.
`define FCST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/fcst_pkg.sv
// Package with sizes, operation codes and cell control type for the set table.
package fcst_pkg;

	localparam int CAPACITY  = 16;
	localparam int KEY_WIDTH = 32;
	localparam int COUNT_W   = $clog2(CAPACITY + 1);

	localparam logic [1:0] OP_ADD      = 2'd0;
	localparam logic [1:0] OP_REMOVE   = 2'd1;
	localparam logic [1:0] OP_CONTAINS = 2'd2;
	localparam logic [1:0] OP_CLEAR    = 2'd3;

	typedef logic [KEY_WIDTH-1:0] key_t;

	typedef struct packed {
		logic occupied;  // slot lies below the entry count
		logic is_last;   // slot holds the last stored entry
		logic append;    // load the lookup key into this slot
		logic fill;      // load the tail key into this slot if it matches
	} cell_ctrl_t;

endpackage

>>> src/fcst_if.sv
// Handshake interfaces for the request and response channels of the set table.
interface fcst_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] key;

	modport source (output valid, output operation, output key, input ready);
	modport sink   (input valid, input operation, input key, output ready);
endinterface

interface fcst_out_if;
	logic       valid;
	logic       ready;
	logic       success;
	logic [4:0] entry_count;
	logic       set_empty;

	modport source (output valid, output success, output entry_count, output set_empty,
		input ready);
	modport sink   (input valid, input success, input entry_count, input set_empty,
		output ready);
endinterface

>>> src/fcst_cell.sv
// One storage cell of the set table: holds a key, compares it and feeds the chain.
module fcst_cell (
	input  logic                clk,
	input  fcst_pkg::cell_ctrl_t ctrl,
	input  fcst_pkg::key_t      lookup_key,
	input  logic                found_in,
	input  fcst_pkg::key_t      tail_in,
	input  fcst_pkg::key_t      tail_key,
	output logic                found_out,
	output fcst_pkg::key_t      tail_out,
	output logic                hit
);

	fcst_pkg::key_t key_q;

	assign hit       = ctrl.occupied && (key_q == lookup_key);
	assign found_out = found_in | hit;
	assign tail_out  = tail_in | (ctrl.is_last ? key_q : '0);

	// Load an appended key, or take the tail entry into a freed slot.
	always_ff @(posedge clk) begin
		if (ctrl.append) begin
			key_q <= lookup_key;
		end else if (ctrl.fill && hit) begin
			key_q <= tail_key;
		end
	end

endmodule

>>> src/fixed_capacity_set_table.sv
// Top level of the fixed-capacity set table built from a chain of key cells.
//
//   channel | dir | payload                               | accepted when
//   --------+-----+---------------------------------------+-------------------
//   req     | in  | operation[1:0], key[31:0]             | valid && ready
//   rsp     | out | success, entry_count[4:0], set_empty  | valid && ready
//
// Each operation has a transfer that registers the request and then an
// execute cycle that compares the key in every cell, ORs the hits and the tail
// key along the chain and writes back the append or swap-remove.
// The execute cycle waits while a finished response is still held; the
// request side stays closed until the execute cycle has run.
// Reset clears the entry count and the handshake state; cell keys are
// undefined until written and are only compared below the entry count.
`include "fixed_capacity_set_table_macros.svh"

module fixed_capacity_set_table (
	input  logic        clk,
	input  logic        arst_n,
	fcst_in_if.sink     req,
	fcst_out_if.source  rsp
);

	localparam int CAP = fcst_pkg::CAPACITY;
	localparam int CW  = fcst_pkg::COUNT_W;

	// Request register and handshake state
	logic                       busy_q;
	logic [1:0]                 op_s1;
	fcst_pkg::key_t             key_s1;
	logic [CW-1:0]              count_q;

	// Response register
	logic                       rsp_valid_q;
	logic                       rsp_success_q;
	logic [CW-1:0]              rsp_count_q;

	// Chain signals; slot 0 is the chain input and slot CAP its end
	logic [CAP:0]               found_chain;
	fcst_pkg::key_t             tail_chain [CAP+1];
	logic [CAP-1:0]             hit_vec;
	fcst_pkg::cell_ctrl_t       ctrl [CAP];

	logic                       exec_go;
	logic                       found;
	logic                       room;
	logic                       add_go;
	logic                       rm_go;
	logic                       ok;
	logic [CW-1:0]              count_nxt;

	assign req.ready = !busy_q;

	// Execute once the response slot is free or being drained this cycle.
	assign exec_go = busy_q && (!rsp_valid_q || rsp.ready);
	assign found   = found_chain[CAP];
	assign room    = count_q < CW'(CAP);

	always_comb begin
		add_go    = 1'b0;
		rm_go     = 1'b0;
		ok        = 1'b0;
		count_nxt = count_q;
		unique case (op_s1)
			fcst_pkg::OP_ADD: begin
				ok = room;
				if (room && !found) begin
					add_go    = exec_go;
					count_nxt = count_q + CW'(1);
				end
			end
			fcst_pkg::OP_REMOVE: begin
				ok = found;
				if (found) begin
					rm_go     = exec_go;
					count_nxt = count_q - CW'(1);
				end
			end
			fcst_pkg::OP_CONTAINS: begin
				ok = found;
			end
			fcst_pkg::OP_CLEAR: begin
				ok        = 1'b1;
				count_nxt = '0;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	assign found_chain[0] = 1'b0;
	assign tail_chain[0]  = '0;

	// Build the row of cells; each hands its hit and tail key to the next.
	for (genvar i = 0; i < CAP; i++) begin : g_cell
		assign ctrl[i].occupied = CW'(i) < count_q;
		assign ctrl[i].is_last  = CW'(i + 1) == count_q;
		assign ctrl[i].append   = add_go && (CW'(i) == count_q);
		assign ctrl[i].fill     = rm_go;

		fcst_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl[i]),
			.lookup_key (key_s1),
			.found_in   (found_chain[i]),
			.tail_in    (tail_chain[i]),
			.tail_key   (tail_chain[CAP]),
			.found_out  (found_chain[i+1]),
			.tail_out   (tail_chain[i+1]),
			.hit        (hit_vec[i])
		);
	end

	// Cells other than the tail add zero, so the end of the chain carries
	// the tail key; feed it back to every cell for the swap-remove fill.
	// Hold the request until the execute cycle runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			busy_q <= 1'b1;
		end else if (exec_go) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1  <= req.operation;
			key_s1 <= req.key[fcst_pkg::KEY_WIDTH-1:0];
		end
	end

	// Load the next entry count on every execute cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (exec_go) begin
			count_q <= count_nxt;
		end
	end

	// Response register: load on execute, drop after the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			rsp_success_q <= ok;
			rsp_count_q   <= count_nxt;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.success     = rsp_success_q;
	assign rsp.entry_count = 5'(rsp_count_q);
	assign rsp.set_empty   = rsp_count_q == '0;

	`FCST_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(CAP), "entry count above capacity")
	`FCST_ASSERT_ALWAYS(a_unique_hit, $onehot0(hit_vec), "key stored in more than one cell")
	`FCST_ASSERT_NEXT(a_remove_dec, rm_go, count_q == $past(count_q) - CW'(1),
		"remove did not lower the entry count")
	`FCST_ASSERT_NEXT(a_add_full, exec_go && op_s1 == fcst_pkg::OP_ADD && !room,
		!rsp_success_q && count_q == $past(count_q), "add on a full set changed state")

endmodule
